[sv/bdpf_pkg.sv]
// shared types, constants and duration table of the bit duration packet framer
`default_nettype none

package bdpf_pkg;

    localparam int BITS_PER_BYTE = 8;

    localparam int RATE_W     = 3;
    localparam int PRE_W      = 6;
    localparam int ACK_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int DUR_W      = 12;
    localparam int HALF_W     = 11;
    localparam int KIND_W     = 3;
    localparam int CNT_W      = 5;

    localparam logic [PRE_W-1:0] MAX_PREAMBLE = PRE_W'(32);
    localparam logic [ACK_W-1:0] MAX_ACKREQ   = ACK_W'(16);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACKREQ_BITS   = 2'd2;

    // symbol kinds
    localparam logic [KIND_W-1:0] KIND_PREAMBLE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DATA     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACKREQ   = 3'd4;

    // duration selectors
    localparam logic [1:0] DUR_ONE  = 2'd0;
    localparam logic [1:0] DUR_ZERO = 2'd1;
    localparam logic [1:0] DUR_ACK  = 2'd2;

    // bit counter operations
    localparam logic [2:0] CNT_HOLD = 3'd0;
    localparam logic [2:0] CNT_DEC  = 3'd1;
    localparam logic [2:0] CNT_PRE  = 3'd2;
    localparam logic [2:0] CNT_DATA = 3'd3;
    localparam logic [2:0] CNT_ACK  = 3'd4;

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] data_byte;
        logic                     final_byte;
    } t_in_item;

    typedef struct packed {
        logic              line_level;
        logic [HALF_W-1:0] first_half;
        logic [HALF_W-1:0] second_half;
        logic [KIND_W-1:0] symbol_kind;
        logic              run_end;
    } t_out_item;

    typedef struct packed {
        logic              load;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              run_end;
        logic              pkt_done;
        logic [2:0]        cnt_op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic final_byte;
        logic ack_zero;
    } t_dp_status;

    function automatic logic [DUR_W-1:0] dur_lookup(input logic [RATE_W-1:0] rate,
                                                    input logic [1:0] which);
        logic [DUR_W-1:0] one_d;
        logic [DUR_W-1:0] zero_d;
        logic [DUR_W-1:0] ack_d;
        logic [DUR_W-1:0] res;
        unique case (rate)
            3'd0: begin
                one_d = 12'd1200; zero_d = 12'd2400; ack_d = 12'd3600;
            end
            3'd1: begin
                one_d = 12'd10; zero_d = 12'd20; ack_d = 12'd60;
            end
            3'd2: begin
                one_d = 12'd20; zero_d = 12'd40; ack_d = 12'd60;
            end
            3'd3: begin
                one_d = 12'd40; zero_d = 12'd80; ack_d = 12'd120;
            end
            3'd4: begin
                one_d = 12'd75; zero_d = 12'd150; ack_d = 12'd225;
            end
            default: begin
                one_d = '0; zero_d = '0; ack_d = '0;
            end
        endcase
        unique case (which)
            DUR_ONE:  res = one_d;
            DUR_ZERO: res = zero_d;
            DUR_ACK:  res = ack_d;
            default:  res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/bdpf_ctrl.sv]
// symbol sequencing state machine of the bit duration packet framer
`default_nettype none

module bdpf_ctrl
    import bdpf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_ACK   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_open;   // packet in progress, next byte skips the preamble
    logic       n_open;

    always_comb begin
        n_state      = r_state;
        n_open       = r_open;
        o_cmd        = '0;
        o_cmd.cnt_op = CNT_HOLD;
        o_in_ready   = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (r_open) begin
                        n_state = ST_START;
                    end else begin
                        n_state      = ST_PRE;
                        o_cmd.cnt_op = CNT_PRE;
                    end
                end
            end
            ST_PRE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_PREAMBLE;
                    if (i_status.cnt_zero) begin
                        n_state = ST_START;
                    end else begin
                        o_cmd.cnt_op = CNT_DEC;
                    end
                end
            end
            ST_START: begin
                if (i_status.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_START;
                    o_cmd.cnt_op = CNT_DATA;
                    n_state      = ST_DATA;
                end
            end
            ST_DATA: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_DATA;
                    if (!i_status.cnt_zero) begin
                        o_cmd.cnt_op = CNT_DEC;
                    end else if (i_status.final_byte) begin
                        n_state = ST_END;
                    end else begin
                        o_cmd.run_end = 1'b1;
                        n_open        = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            ST_END: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_END;
                    if (i_status.ack_zero) begin
                        o_cmd.run_end  = 1'b1;
                        o_cmd.pkt_done = 1'b1;
                        n_open         = 1'b0;
                        n_state        = ST_IDLE;
                    end else begin
                        o_cmd.cnt_op = CNT_ACK;
                        n_state      = ST_ACK;
                    end
                end
            end
            ST_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ACKREQ;
                    if (i_status.cnt_zero) begin
                        o_cmd.run_end  = 1'b1;
                        o_cmd.pkt_done = 1'b1;
                        n_open         = 1'b0;
                        n_state        = ST_IDLE;
                    end else begin
                        o_cmd.cnt_op = CNT_DEC;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_open  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
        end
    end

endmodule

`default_nettype wire

[sv/bdpf_dp.sv]
// datapath of the bit duration packet framer: config, byte shifter, counter, output register
`default_nettype none

module bdpf_dp
    import bdpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_ready,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    output logic                       o_out_valid,
    output t_out_item                  o_out_item
);

    logic [RATE_W-1:0]        r_rate;
    logic [PRE_W-1:0]         r_pre;
    logic [ACK_W-1:0]         r_ack;
    logic [BITS_PER_BYTE-1:0] r_byte;
    logic                     r_final;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic                     r_level;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [CNT_W-1:0] pre_load;
    logic [CNT_W-1:0] ack_load;
    logic [1:0]       dur_sel;
    logic [DUR_W-1:0] dur;
    logic [DUR_W:0]   dur_inc;

    // preamble count clamped to 1..32, ackreq count clamped to 16, both minus one
    always_comb begin
        if (r_pre == '0) begin
            pre_load = '0;
        end else if (r_pre > MAX_PREAMBLE) begin
            pre_load = CNT_W'(MAX_PREAMBLE - PRE_W'(1));
        end else begin
            pre_load = CNT_W'(r_pre - PRE_W'(1));
        end
        if (r_ack > MAX_ACKREQ) begin
            ack_load = CNT_W'(MAX_ACKREQ - ACK_W'(1));
        end else begin
            ack_load = CNT_W'(r_ack - ACK_W'(1));
        end
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_DEC:  n_cnt = r_cnt - CNT_W'(1);
            CNT_PRE:  n_cnt = pre_load;
            CNT_DATA: n_cnt = CNT_W'(BITS_PER_BYTE - 1);
            CNT_ACK:  n_cnt = ack_load;
            default:  n_cnt = r_cnt;
        endcase
    end

    always_comb begin
        case (i_cmd.kind)
            KIND_START:  dur_sel = DUR_ZERO;
            KIND_DATA:   dur_sel = r_byte[BITS_PER_BYTE-1] ? DUR_ONE : DUR_ZERO;
            KIND_ACKREQ: dur_sel = DUR_ACK;
            default:     dur_sel = DUR_ONE;
        endcase
        dur     = dur_lookup(r_rate, dur_sel);
        dur_inc = {1'b0, dur} + (DUR_W+1)'(1);
    end

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.cnt_zero   = (r_cnt == '0);
    assign o_status.final_byte = r_final;
    assign o_status.ack_zero   = (r_ack == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= '0;
            r_pre  <= PRE_W'(16);
            r_ack  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRANSFER_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                CFG_PREAMBLE_BITS: r_pre  <= i_cfg_data[PRE_W-1:0];
                CFG_ACKREQ_BITS:   r_ack  <= i_cfg_data[ACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_level     <= i_cmd.pkt_done ? 1'b0 : ~r_level;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte  <= i_in_item.data_byte;
            r_final <= i_in_item.final_byte;
        end else if (i_cmd.emit && i_cmd.kind == KIND_DATA) begin
            r_byte <= {r_byte[BITS_PER_BYTE-2:0], 1'b0};
        end
        if (i_cmd.emit) begin
            r_out.line_level  <= r_level;
            r_out.first_half  <= HALF_W'(dur >> 1);
            r_out.second_half <= HALF_W'(dur_inc >> 1);
            r_out.symbol_kind <= i_cmd.kind;
            r_out.run_end     <= i_cmd.run_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

[sv/bit_duration_packet_framer.sv]
// top level of the bit duration packet framer
//
// Turns packet bytes into line symbols, one symbol per clock while the output
// side keeps taking them and a byte is being sent; a new byte is accepted only
// when the last one has issued its symbols. A byte is sent as a start bit and
// eight data bits; the first byte of a packet is preceded by its preamble bits
// (1..32), the final byte adds the end bit and its ackreq symbols (0..16).
// The rate is set by the single symbol output register, which is refilled in
// the same cycle its item is taken. Each symbol carries its level, the two
// half durations in ticks, its kind and a run_end flag on the last symbol of a
// byte. The level toggles per symbol and returns to low after a packet's last
// symbol. Configuration writes are taken on every cycle and must only be
// issued while the block is idle; unknown register indexes are ignored.
`default_nettype none

module bit_duration_packet_framer
    import bdpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // byte input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    // symbol output
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    // sequencer: picks the next symbol kind and counter action
    bdpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: config registers, byte shifter, bit counter, line level, output register
    bdpf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // an accepted byte always closes the input in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accepting an item");

    // while a symbol that does not end its byte is shown, the byte is still at work
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.run_end) |-> !o_in_ready)
        else $error("input ready while a byte is still being sent");

    // a new symbol only appears from work on a byte, never while the block was idle
    a_symbol_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("symbol produced while idle");

endmodule

`default_nettype wire

[tb/sv/bit_duration_packet_framer_checker.sv]
// symbol predictor and comparator for the bit duration packet framer
`timescale 1ns / 1ps

module bit_duration_packet_framer_checker
    import bdpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_item             i_out_item,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_mismatches,
    output int                         o_symbols_seen
);

    // tick durations per transfer rate
    localparam int unsigned ONE_TICKS  [0:4] = '{1200, 10, 20, 40, 75};
    localparam int unsigned ZERO_TICKS [0:4] = '{2400, 20, 40, 80, 150};
    localparam int unsigned ACK_TICKS  [0:4] = '{3600, 60, 60, 120, 225};
    localparam int REPORT_LIMIT = 100;

    logic [RATE_W-1:0] rate;
    logic [PRE_W-1:0]  preamble_len;
    logic [ACK_W-1:0]  ackreq_len;
    logic              in_packet;
    logic              level;
    t_out_item         expected_symbols [$];
    int                errors;
    int                seen;

    function automatic int unsigned ticks(input logic [1:0] which);
        int unsigned d;
        d = 0;
        if (rate <= RATE_W'(4)) begin
            case (which)
                DUR_ONE:  d = ONE_TICKS[rate];
                DUR_ZERO: d = ZERO_TICKS[rate];
                DUR_ACK:  d = ACK_TICKS[rate];
                default:  d = 0;
            endcase
        end
        return d;
    endfunction

    function automatic void emit(input logic [KIND_W-1:0] kind, input int unsigned d);
        t_out_item s;
        s.line_level  = level;
        s.first_half  = HALF_W'(d / 2);
        s.second_half = HALF_W'((d + 1) / 2);
        s.symbol_kind = kind;
        s.run_end     = 1'b0;
        expected_symbols.push_back(s);
        level = ~level;
    endfunction

    function automatic void predict_byte(input t_in_item it);
        int unsigned one_d;
        int unsigned zero_d;
        int unsigned n;
        one_d  = ticks(DUR_ONE);
        zero_d = ticks(DUR_ZERO);
        if (!in_packet) begin
            n = (preamble_len == '0) ? 1 :
                (preamble_len > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_len;
            repeat (n) emit(KIND_PREAMBLE, one_d);
        end
        emit(KIND_START, zero_d);
        for (int i = BITS_PER_BYTE - 1; i >= 0; i--)
            emit(KIND_DATA, it.data_byte[i] ? one_d : zero_d);
        if (it.final_byte) begin
            emit(KIND_END, one_d);
            n = (ackreq_len > MAX_ACKREQ) ? MAX_ACKREQ : ackreq_len;
            repeat (n) emit(KIND_ACKREQ, ticks(DUR_ACK));
            level     = 1'b0;
            in_packet = 1'b0;
        end else begin
            in_packet = 1'b1;
        end
        expected_symbols[expected_symbols.size() - 1].run_end = 1'b1;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rate         = '0;
            preamble_len = PRE_W'(16);
            ackreq_len   = '0;
            in_packet    = 1'b0;
            level        = 1'b0;
            errors       = 0;
            seen         = 0;
            expected_symbols.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TRANSFER_RATE: rate         = i_cfg_data[RATE_W-1:0];
                    CFG_PREAMBLE_BITS: preamble_len = i_cfg_data[PRE_W-1:0];
                    CFG_ACKREQ_BITS:   ackreq_len   = i_cfg_data[ACK_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_byte(i_in_item);
            if (i_out_valid && i_out_ready) begin
                seen++;
                if (expected_symbols.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $error("symbol with none expected: kind %0d level %0d",
                               i_out_item.symbol_kind, i_out_item.line_level);
                end else begin
                    want = expected_symbols.pop_front();
                    check_field("line_level", want.line_level, i_out_item.line_level);
                    check_field("first_half", want.first_half, i_out_item.first_half);
                    check_field("second_half", want.second_half, i_out_item.second_half);
                    check_field("symbol_kind", want.symbol_kind, i_out_item.symbol_kind);
                    check_field("run_end", want.run_end, i_out_item.run_end);
                end
            end
        end
        o_pending      <= expected_symbols.size();
        o_mismatches   <= errors;
        o_symbols_seen <= seen;
    end

endmodule

[tb/sv/bit_duration_packet_framer_tb.sv]
// stimulus, receiver stalls, watchdog and verdict for the bit duration packet framer
`timescale 1ns / 1ps

module bit_duration_packet_framer_tb;
    import bdpf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_BYTES = 460;
    // nothing is taken for this long: slowest item is 58 symbols, receiver stalls
    // and sender gaps are bounded, so this is generous
    localparam int IDLE_LIMIT   = 2000;
    // quiet cycles after the last symbol, to catch stray output
    localparam int TAIL_CYCLES  = 80;

    // register index the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // receiver behavior
    localparam logic [1:0] RX_STREAM = 2'd0;
    localparam logic [1:0] RX_LIGHT  = 2'd1;
    localparam logic [1:0] RX_HEAVY  = 2'd2;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    pending;
    int                    mismatches;
    int                    symbols_seen;

    logic [1:0]            rx_mode   = RX_STREAM;
    int                    rx_hold   = 0;
    int                    idle_cycles = 0;
    int                    bytes_sent  = 0;
    int                    packets_closed = 0;
    int                    settings_used  = 0;

    bit_duration_packet_framer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bit_duration_packet_framer_checker symbol_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_item     (out_item),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_mismatches   (mismatches),
        .o_symbols_seen (symbols_seen)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // symbol receiver: streaming, light random stalls, or long stall runs
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            case (rx_mode)
                RX_STREAM: begin
                    out_ready <= 1'b1;
                end
                RX_LIGHT: begin
                    out_ready <= ($urandom_range(0, 3) != 0);
                    rx_hold   <= $urandom_range(0, 3);
                end
                default: begin
                    // alternate short ready windows with random-length stalls
                    if (out_ready) begin
                        out_ready <= 1'b0;
                        rx_hold   <= $urandom_range(1, 19);
                    end else begin
                        out_ready <= 1'b1;
                        rx_hold   <= $urandom_range(0, 7);
                    end
                end
            endcase
        end
    end

    // watchdog on cycles in which no channel moves an item
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one byte and hold it until taken; valid stays high for the caller
    task automatic push_byte(input logic [BITS_PER_BYTE-1:0] value, input logic closes);
        in_valid <= 1'b1;
        in_item  <= '{data_byte: value, final_byte: closes};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        if (closes) packets_closed++;
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending and wait until every predicted symbol has come out
    task automatic settle_line();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // one register write; valid stays high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // all three registers, unused upper data bits random, sometimes a write
    // to the index with no register first
    task automatic program_line(input logic [RATE_W-1:0] rate,
                                input logic [PRE_W-1:0]  preamble,
                                input logic [ACK_W-1:0]  ackreq);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        write_reg(CFG_TRANSFER_RATE, {(CFG_DATA_W-RATE_W)'($urandom), rate});
        write_reg(CFG_PREAMBLE_BITS, preamble);
        write_reg(CFG_ACKREQ_BITS, {(CFG_DATA_W-ACK_W)'($urandom), ackreq});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [RATE_W-1:0] rate_pick;
        logic [PRE_W-1:0]  pre_pick;
        logic [ACK_W-1:0]  ack_pick;
        int                random_left;
        int                packets;
        int                len;
        int                burst_left;
        bit                gaps_on;
        bit                leave_open;

        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings first, a two-byte packet of all zeros then
        // all ones, and a single-byte packet
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hA5, 1'b1);
        settle_line();

        // zero preamble count sends one preamble bit, full ackreq trailer
        rx_mode <= RX_HEAVY;
        program_line(3'd1, 6'd0, 5'd16);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);
        settle_line();

        // rate with no table entry, preamble and ackreq counts past their caps
        program_line(3'd7, 6'd63, 5'd31);
        push_byte(8'h5A, 1'b1);
        settle_line();

        // slowest rate in ticks of the fast ones, max preamble, ackreq just past max
        rx_mode <= RX_LIGHT;
        program_line(3'd4, 6'd32, 5'd17);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'h96, 1'b1);
        settle_line();

        program_line(3'd2, 6'd1, 5'd1);
        push_byte(8'h7F, 1'b1);
        settle_line();

        program_line(3'd3, 6'd33, 5'd0);
        push_byte(8'hFE, 1'b1);
        settle_line();

        program_line(3'd5, 6'd2, 5'd2);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        settle_line();

        program_line(3'd6, 6'd1, 5'd0);
        push_byte(8'h0F, 1'b1);

        // random phases: each one drains the line, picks new settings and a
        // receiver behavior, then sends a run of packets
        random_left = RANDOM_BYTES;
        while (random_left > 0) begin
            settle_line();

            rate_pick = ($urandom_range(0, 7) == 0) ? RATE_W'($urandom_range(5, 7))
                                                    : RATE_W'($urandom_range(0, 4));
            case ($urandom_range(0, 9))
                0:       pre_pick = '0;
                1:       pre_pick = PRE_W'(32);
                2:       pre_pick = PRE_W'($urandom_range(33, 63));
                default: pre_pick = PRE_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       ack_pick = ACK_W'(16);
                1:       ack_pick = ACK_W'($urandom_range(17, 31));
                default: ack_pick = ACK_W'($urandom_range(0, 3));
            endcase
            program_line(rate_pick, pre_pick, ack_pick);

            case ($urandom_range(0, 2))
                0:       rx_mode <= RX_STREAM;
                1:       rx_mode <= RX_LIGHT;
                default: rx_mode <= RX_HEAVY;
            endcase
            gaps_on    = ($urandom_range(0, 2) != 0);
            leave_open = ($urandom_range(0, 4) == 0);
            burst_left = $urandom_range(1, 10);
            packets    = $urandom_range(2, 8);

            for (int p = 0; p < packets && random_left > 0; p++) begin
                // mostly short packets, now and then a long one
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 16)
                                                  : $urandom_range(1, 4);
                for (int b = 0; b < len && random_left > 0; b++) begin
                    if (gaps_on && burst_left == 0) begin
                        pause_sender($urandom_range(1, 12));
                        burst_left = $urandom_range(1, 10);
                    end
                    // last packet of a phase may stay open across the next settings
                    push_byte(BITS_PER_BYTE'($urandom),
                              (b == len - 1) && !(leave_open && p == packets - 1));
                    random_left--;
                    burst_left--;
                end
            end
        end

        settle_line();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bytes, %0d closed packets, %0d register settings",
                 bytes_sent, packets_closed, settings_used);
        $display("compared %0d line symbols against prediction", symbols_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
sv/bdpf_pkg.sv
sv/bdpf_ctrl.sv
sv/bdpf_dp.sv
sv/bit_duration_packet_framer.sv
tb/sv/bit_duration_packet_framer_checker.sv
tb/sv/bit_duration_packet_framer_tb.sv
